[hw/rtl/gba_pkg.sv]
// Shared types and constants for the glyph bilinear alpha blit unit.
// Used by the channel interfaces' users, front, queue, back and top level.
package gba_pkg;

    // Atlas geometry
    localparam int unsigned ATLAS_DIM_DEF = 256;
    localparam int unsigned ATLAS_AW      = 16;
    localparam int unsigned ATLAS_DEPTH   = 65536;

    // Work queue between front and back
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_PW    = 2;

    // Item function codes
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_RENDER = 1'b1;

    // Configuration register indexes
    localparam logic CFG_TEXT_COLOR = 1'b0;
    localparam logic CFG_INV_SCALE  = 1'b1;

    localparam logic [23:0] TEXT_COLOR_RST = 24'hFF_FFFF;
    localparam logic [11:0] INV_SCALE_RST  = 12'd256;

    // One classified item on its way from front to back
    typedef struct packed {
        logic        is_load;
        logic [7:0]  wbyte;
        logic [7:0]  u;
        logic [7:0]  w;
        logic [23:0] dest;
        logic [15:0] row0;
        logic [15:0] row1;
        logic [8:0]  c0;
    } t_work;

    // Queue status seen by the top level
    typedef struct packed {
        logic                 push;
        logic                 pop;
        logic                 full;
        logic                 empty;
        logic [FIFO_PW:0]     count;
    } t_fifo_stat;

endpackage

[hw/rtl/gba_if.sv]
// Valid/ready channel interfaces for render/load items and blended pixels.
// No dependencies.
interface gba_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [15:0] atlas_addr;
    logic [7:0]  atlas_byte;
    logic [7:0]  glyph_left;
    logic [7:0]  glyph_top;
    logic [7:0]  glyph_wide;
    logic [7:0]  glyph_tall;
    logic [10:0] pix_col;
    logic [10:0] pix_row;
    logic [23:0] dest_pixel;

    modport source (output valid, func, atlas_addr, atlas_byte, glyph_left, glyph_top,
                    glyph_wide, glyph_tall, pix_col, pix_row, dest_pixel, input ready);
    modport sink   (input valid, func, atlas_addr, atlas_byte, glyph_left, glyph_top,
                    glyph_wide, glyph_tall, pix_col, pix_row, dest_pixel, output ready);
endinterface

interface gba_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] new_pixel;
    logic        write_enable;
    logic [7:0]  coverage;

    modport source (output valid, new_pixel, write_enable, coverage, input ready);
    modport sink   (input valid, new_pixel, write_enable, coverage, output ready);
endinterface

[hw/rtl/gba_front.sv]
// Front end: accepts items, maps the pixel center into the glyph and forms row bases.
// Depends on gba_pkg and gba_in_if.
module gba_front #(
    parameter int unsigned ATLAS_DIM = gba_pkg::ATLAS_DIM_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    gba_in_if.sink         i_in,
    input  logic [11:0]    i_inv_scale,
    input  logic           i_fifo_ready,
    output logic           o_push,
    output gba_pkg::t_work o_work
);
    import gba_pkg::*;

    localparam int unsigned DIM_W = $clog2(ATLAS_DIM + 1);
    localparam int unsigned MUL_W = 9 + DIM_W;

    logic en_f;

    // Stage 1 registers
    logic        r_f1_valid, n_f1_valid;
    logic        r_f1_load;
    logic [15:0] r_f1_addr;
    logic [7:0]  r_f1_byte, r_f1_left, r_f1_top, r_f1_wide, r_f1_tall;
    logic [23:0] r_f1_dest, r_f1_px, r_f1_py;

    // Stage 2 registers
    logic        r_f2_valid;
    logic        r_f2_load;
    logic [15:0] r_f2_addr;
    logic [7:0]  r_f2_byte, r_f2_u, r_f2_w;
    logic [23:0] r_f2_dest;
    logic [8:0]  r_f2_r0, r_f2_c0;

    // Stage 3 registers
    logic  r_f3_valid;
    t_work r_f3_work, n_f3_work;

    logic [23:0] px_sub, py_sub;
    logic [22:0] px_p, py_p;
    logic [15:0] lim_x, lim_y, pos_x, pos_y;
    logic [MUL_W-1:0] mul0, mul1;

    // Stall the whole front only when the last stage cannot leave
    assign en_f       = !r_f3_valid || i_fifo_ready;
    assign i_in.ready = en_f;
    assign o_push     = r_f3_valid && i_fifo_ready;
    assign o_work     = r_f3_work;

    // Drop empty glyphs here; loads always go on
    assign n_f1_valid = i_in.valid && (i_in.func == FUNC_LOAD ||
                        (i_in.glyph_wide != 8'd0 && i_in.glyph_tall != 8'd0));

    // Clamp the source position into the glyph
    always_comb begin
        px_sub = r_f1_px - 24'd256;
        py_sub = r_f1_py - 24'd256;
        px_p   = (r_f1_px < 24'd256) ? 23'd0 : px_sub[23:1];
        py_p   = (r_f1_py < 24'd256) ? 23'd0 : py_sub[23:1];
        lim_x  = {r_f1_wide - 8'd1, 8'h00};
        lim_y  = {r_f1_tall - 8'd1, 8'h00};
        pos_x  = (px_p > 23'(lim_x)) ? lim_x : px_p[15:0];
        pos_y  = (py_p > 23'(lim_y)) ? lim_y : py_p[15:0];
    end

    // Row bases of the two sample rows
    always_comb begin
        mul0 = MUL_W'(r_f2_r0) * MUL_W'(ATLAS_DIM);
        mul1 = (MUL_W'(r_f2_r0) + MUL_W'(1)) * MUL_W'(ATLAS_DIM);
        n_f3_work.is_load = r_f2_load;
        n_f3_work.wbyte   = r_f2_byte;
        n_f3_work.u       = r_f2_u;
        n_f3_work.w       = r_f2_w;
        n_f3_work.dest    = r_f2_dest;
        if (r_f2_load) begin
            n_f3_work.row0 = r_f2_addr;
            n_f3_work.row1 = r_f2_addr;
            n_f3_work.c0   = 9'd0;
        end else begin
            n_f3_work.row0 = 16'(mul0);
            n_f3_work.row1 = 16'(mul1);
            n_f3_work.c0   = r_f2_c0;
        end
    end

    // Advance control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
            r_f2_valid <= 1'b0;
            r_f3_valid <= 1'b0;
        end else if (en_f) begin
            r_f1_valid <= n_f1_valid;
            r_f2_valid <= r_f1_valid;
            r_f3_valid <= r_f2_valid;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (en_f) begin
            r_f1_load <= (i_in.func == FUNC_LOAD);
            r_f1_addr <= i_in.atlas_addr;
            r_f1_byte <= i_in.atlas_byte;
            r_f1_left <= i_in.glyph_left;
            r_f1_top  <= i_in.glyph_top;
            r_f1_wide <= i_in.glyph_wide;
            r_f1_tall <= i_in.glyph_tall;
            r_f1_dest <= i_in.dest_pixel;
            r_f1_px   <= {i_in.pix_col, 1'b1} * i_inv_scale;
            r_f1_py   <= {i_in.pix_row, 1'b1} * i_inv_scale;

            r_f2_load <= r_f1_load;
            r_f2_addr <= r_f1_addr;
            r_f2_byte <= r_f1_byte;
            r_f2_dest <= r_f1_dest;
            r_f2_u    <= pos_x[7:0];
            r_f2_w    <= pos_y[7:0];
            r_f2_r0   <= 9'(r_f1_top) + 9'(pos_y[15:8]);
            r_f2_c0   <= 9'(r_f1_left) + 9'(pos_x[15:8]);

            r_f3_work <= n_f3_work;
        end
    end
endmodule

[hw/rtl/gba_fifo.sv]
// Short work queue between front and back.
// Depends on gba_pkg.
module gba_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  gba_pkg::t_work      i_work,
    output logic                o_ready,
    input  logic                i_pop,
    output logic                o_valid,
    output gba_pkg::t_work      o_work,
    output gba_pkg::t_fifo_stat o_stat
);
    import gba_pkg::*;

    t_work              r_slot [FIFO_DEPTH];
    logic [FIFO_PW-1:0] r_wp, r_rp;
    logic [FIFO_PW:0]   r_count;

    assign o_ready = (r_count != (FIFO_PW+1)'(FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_work  = r_slot[r_rp];

    assign o_stat.push  = i_push;
    assign o_stat.pop   = i_pop;
    assign o_stat.full  = !o_ready;
    assign o_stat.empty = !o_valid;
    assign o_stat.count = r_count;

    // Move pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wp] <= i_work;
    end
endmodule

[hw/rtl/gba_back.sv]
// Back end: atlas memories, bilinear filter, rounding and alpha blend.
// Depends on gba_pkg and gba_out_if.
module gba_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [23:0]    i_text_color,
    input  logic           i_valid,
    input  gba_pkg::t_work i_work,
    output logic           o_pop,
    gba_out_if.source      o_out
);
    import gba_pkg::*;

    logic en_b;

    // Two copies of the atlas, each with two read ports
    logic [7:0] r_atlas_a [ATLAS_DEPTH];
    logic [7:0] r_atlas_b [ATLAS_DEPTH];

    logic [ATLAS_AW-1:0] addr00, addr01, addr10, addr11;

    logic        r_b1_valid, r_b2_valid, r_b3_valid, r_b4_valid, r_b5_valid;
    logic [7:0]  r_s00, r_s01, r_s10, r_s11, r_b1_u, r_b1_w, r_b2_w;
    logic [23:0] r_b1_dest, r_b2_dest, r_b3_dest, r_b4_dest;
    logic [15:0] r_b2_upper, r_b2_lower;
    logic [7:0]  r_b3_ai, r_b4_ai;
    logic [15:0] r_b4_sum [3];
    logic [23:0] r_b5_pix;
    logic        r_b5_we;
    logic [7:0]  r_b5_cov;

    logic [8:0]  inv_u, inv_w;
    logic [16:0] upper, lower;
    logic [24:0] alpha;
    logic [24:0] alpha_rnd;
    logic [15:0] sum [3];
    logic [16:0] qx [3];
    logic [23:0] blend;

    assign en_b  = !r_b5_valid || o_out.ready;
    assign o_pop = en_b && i_valid;

    assign o_out.valid        = r_b5_valid;
    assign o_out.new_pixel    = r_b5_pix;
    assign o_out.write_enable = r_b5_we;
    assign o_out.coverage     = r_b5_cov;

    // Sample addresses of the four neighbors
    always_comb begin
        addr00 = i_work.row0 + 16'(i_work.c0);
        addr01 = i_work.row0 + 16'(i_work.c0) + 16'd1;
        addr10 = i_work.row1 + 16'(i_work.c0);
        addr11 = i_work.row1 + 16'(i_work.c0) + 16'd1;
    end

    // Write loads, read renders
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            if (i_work.is_load) begin
                r_atlas_a[addr00] <= i_work.wbyte;
                r_atlas_b[addr00] <= i_work.wbyte;
            end else begin
                r_s00 <= r_atlas_a[addr00];
                r_s01 <= r_atlas_a[addr01];
                r_s10 <= r_atlas_b[addr10];
                r_s11 <= r_atlas_b[addr11];
            end
        end
    end

    // Filter and blend arithmetic
    always_comb begin
        inv_u     = 9'd256 - 9'(r_b1_u);
        upper     = 17'(r_s00) * 17'(inv_u) + 17'(r_s01) * 17'(r_b1_u);
        lower     = 17'(r_s10) * 17'(inv_u) + 17'(r_s11) * 17'(r_b1_u);
        inv_w     = 9'd256 - 9'(r_b2_w);
        alpha     = 25'(r_b2_upper) * 25'(inv_w) + 25'(r_b2_lower) * 25'(r_b2_w);
        alpha_rnd = alpha + 25'd32768;
        for (int k = 0; k < 3; k++) begin
            sum[k] = 16'(16'(i_text_color[8*k +: 8]) * 16'(r_b3_ai)
                   + 16'(r_b3_dest[8*k +: 8]) * 16'(8'd255 - r_b3_ai));
            qx[k]  = 17'(r_b4_sum[k]) + 17'(r_b4_sum[k][15:8]) + 17'd1;
            blend[8*k +: 8] = qx[k][15:8];
        end
    end

    // Advance control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
            r_b2_valid <= 1'b0;
            r_b3_valid <= 1'b0;
            r_b4_valid <= 1'b0;
            r_b5_valid <= 1'b0;
        end else if (en_b) begin
            r_b1_valid <= o_pop && !i_work.is_load;
            r_b2_valid <= r_b1_valid;
            r_b3_valid <= r_b2_valid;
            r_b4_valid <= r_b3_valid;
            r_b5_valid <= r_b4_valid;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (en_b) begin
            r_b1_u     <= i_work.u;
            r_b1_w     <= i_work.w;
            r_b1_dest  <= i_work.dest;
            r_b2_upper <= upper[15:0];
            r_b2_lower <= lower[15:0];
            r_b2_w     <= r_b1_w;
            r_b2_dest  <= r_b1_dest;
            r_b3_ai    <= alpha_rnd[23:16];
            r_b3_dest  <= r_b2_dest;
            r_b4_sum   <= sum;
            r_b4_ai    <= r_b3_ai;
            r_b4_dest  <= r_b3_dest;
            r_b5_pix   <= (r_b4_ai == 8'd0) ? r_b4_dest : blend;
            r_b5_we    <= (r_b4_ai != 8'd0);
            r_b5_cov   <= r_b4_ai;
        end
    end
endmodule

[hw/rtl/glyph_bilinear_alpha_blit_unit.sv]
// Top level of the glyph bilinear alpha blit unit: configuration registers,
// front end, work queue and back end. Depends on gba_pkg, gba_if and the gba_ modules.
//
// The unit takes one item per clock while the output is not stalled: loads write one
// atlas byte, renders give one blended pixel. A render passes 3 front stages, the
// queue and 5 back stages; loads and empty glyphs give no result. Four atlas samples
// per cycle come from two atlas copies, each read at two addresses and both written
// by every load. A stalled output fills the 4-entry queue before the input stalls.
// The atlas has no reset; read only what was loaded.
module glyph_bilinear_alpha_blit_unit #(
    parameter int unsigned ATLAS_DIM = gba_pkg::ATLAS_DIM_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    gba_in_if.sink      i_pix,
    gba_out_if.source   o_pix
);
    import gba_pkg::*;

    logic [23:0] r_text_color;
    logic [11:0] r_inv_scale;

    logic       push, pop, fifo_ready, fifo_valid;
    t_work      work_in, work_out;
    t_fifo_stat fifo_stat;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color <= TEXT_COLOR_RST;
            r_inv_scale  <= INV_SCALE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TEXT_COLOR: r_text_color <= i_cfg_data;
                CFG_INV_SCALE:  r_inv_scale  <= i_cfg_data[11:0];
                default:        r_text_color <= r_text_color;
            endcase
        end
    end

    gba_front #(.ATLAS_DIM(ATLAS_DIM)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_pix),
        .i_inv_scale  (r_inv_scale),
        .i_fifo_ready (fifo_ready),
        .o_push       (push),
        .o_work       (work_in)
    );

    gba_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_work  (work_in),
        .o_ready (fifo_ready),
        .i_pop   (pop),
        .o_valid (fifo_valid),
        .o_work  (work_out),
        .o_stat  (fifo_stat)
    );

    gba_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_text_color (r_text_color),
        .i_valid      (fifo_valid),
        .i_work       (work_out),
        .o_pop        (pop),
        .o_out        (o_pix)
    );

    // Queue never takes an entry when full nor gives one when empty
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_stat.full |-> !fifo_stat.push) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_stat.empty |-> !fifo_stat.pop) else $error("queue underflow");
    // Count rises by one after a push without a pop
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fifo_stat.push && !fifo_stat.pop) |=>
        (fifo_stat.count == $past(fifo_stat.count) + 1'b1)) else $error("count slip");
    // Write strobe follows coverage
    a_we_cov: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix.valid |-> (o_pix.write_enable == (o_pix.coverage != 8'd0)))
        else $error("write enable mismatch");
endmodule
